>>> design/asl_pkg.sv
// Shared types and constants of the adaptive size limit controller.
package asl_pkg;

  localparam int unsigned SizeW = 64;
  localparam int unsigned ZETA_FRACTION_BITS = 7;
  localparam int unsigned CntW = $clog2(SizeW);

  localparam logic [SizeW-1:0] ALL_ONES = {SizeW{1'b1}};
  localparam logic [SizeW-1:0] ZETA_UNIT = SizeW'(1) << ZETA_FRACTION_BITS;

  // Configuration register indexes.
  localparam logic [2:0] REG_INIT_CTRL  = 3'd0;
  localparam logic [2:0] REG_INIT_BUF   = 3'd1;
  localparam logic [2:0] REG_GAMMA_RCP  = 3'd2;
  localparam logic [2:0] REG_ZETA       = 3'd3;
  localparam logic [2:0] REG_THETA_RCP  = 3'd4;
  localparam logic [2:0] REG_BUF_GAIN   = 3'd5;
  localparam logic [2:0] REG_MAX_CTRL   = 3'd6;
  localparam logic [2:0] REG_MAX_BUF    = 3'd7;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_CHK,
    MD_DIV
  } md_state_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AMP,
    S_AMPL,
    S_ZB,
    S_OFF,
    S_CSTEP,
    S_THETA,
    S_GAIN,
    S_FIN
  } ctl_state_e;

  typedef struct packed {
    logic             start;
    logic [SizeW-1:0] x;
    logic [SizeW-1:0] y;
    logic [SizeW-1:0] z;
  } md_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [SizeW-1:0] result;
  } md_rsp_t;

endpackage

>>> design/asl_muldiv.sv
// Bit-serial saturating multiply-divide unit: floor(x*y/z), one bit per cycle.
module asl_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  asl_pkg::md_req_t req_i,
  output asl_pkg::md_rsp_t rsp_o
);
  import asl_pkg::*;

  md_state_e        st_q, st_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [SizeW-1:0] hi_q, hi_d, lo_q, lo_d, y_q, y_d, z_q, z_d;
  logic             done_q, done_d;
  logic [SizeW:0]   sum, part, rem2, diff;
  logic             ge, sat;

  always_comb begin
    sum  = {1'b0, hi_q} + {1'b0, y_q};
    part = lo_q[0] ? sum : {1'b0, hi_q};
    rem2 = {hi_q, lo_q[SizeW-1]};
    ge   = rem2 >= {1'b0, z_q};
    diff = rem2 - {1'b0, z_q};
    sat  = (z_q == '0) || (hi_q >= z_q);
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      MD_IDLE: if (req_i.start) st_d = MD_MUL;
      MD_MUL:  if (cnt_q == CntW'(SizeW - 1)) st_d = MD_CHK;
      MD_CHK:  st_d = sat ? MD_IDLE : MD_DIV;
      MD_DIV:  if (cnt_q == CntW'(SizeW - 1)) st_d = MD_IDLE;
      default: st_d = MD_IDLE;
    endcase
  end

  // Datapath.
  always_comb begin
    cnt_d  = cnt_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    y_d    = y_q;
    z_d    = z_q;
    done_d = 1'b0;
    case (st_q)
      MD_IDLE: begin
        if (req_i.start) begin
          hi_d  = '0;
          lo_d  = req_i.x;
          y_d   = req_i.y;
          z_d   = req_i.z;
          cnt_d = '0;
        end
      end
      MD_MUL: begin
        hi_d  = part[SizeW:1];
        lo_d  = {part[0], lo_q[SizeW-1:1]};
        cnt_d = cnt_q + 1'b1;
      end
      MD_CHK: begin
        cnt_d = '0;
        if (sat) begin
          lo_d   = ALL_ONES;
          done_d = 1'b1;
        end
      end
      MD_DIV: begin
        hi_d   = ge ? diff[SizeW-1:0] : rem2[SizeW-1:0];
        lo_d   = {lo_q[SizeW-2:0], ge};
        cnt_d  = cnt_q + 1'b1;
        done_d = (cnt_q == CntW'(SizeW - 1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= MD_IDLE;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    y_q  <= y_d;
    z_q  <= z_d;
  end

  assign rsp_o.busy   = (st_q != MD_IDLE);
  assign rsp_o.done   = done_q;
  assign rsp_o.result = lo_q;

endmodule

>>> design/adaptive_size_limit_controller.sv
// Top level of the adaptive size limit controller: sequencer, state and result register.
// Each transaction runs three passes of one bit-serial multiply-divide unit when the control
// size shrinks or holds and seven when it grows; a pass runs a start, 64 multiply steps, a
// check, 64 divide steps and a hand-over, or ends after the check when the quotient saturates.
// The result then waits until the output register is free; one transaction is in work at a
// time, and the next is taken in the cycle after the result is loaded.
// Reset (asynchronous, active low) loads the configuration registers with their defaults and the
// sizes with their initial values; the stored block size starts at zero. Working registers are not reset.
module adaptive_size_limit_controller (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [asl_pkg::SizeW-1:0] new_block_size_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [asl_pkg::SizeW-1:0] control_size_o,
  output logic [asl_pkg::SizeW-1:0] buffer_size_o,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [asl_pkg::SizeW-1:0] cfg_wdata_i
);
  import asl_pkg::*;

  function automatic logic [SizeW-1:0] sat_add(input logic [SizeW-1:0] a,
                                               input logic [SizeW-1:0] b);
    logic [SizeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SizeW] ? ALL_ONES : s[SizeW-1:0];
  endfunction

  function automatic logic [SizeW-1:0] sat_sub(input logic [SizeW-1:0] a,
                                               input logic [SizeW-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  // Configuration registers.
  logic [SizeW-1:0] init_ctrl_q, init_buf_q, max_ctrl_q, max_buf_q;
  logic [31:0]      gamma_q, theta_q;
  logic [8:0]       zeta_q;
  logic [7:0]       gain_q;

  // Controller state and per-transaction working registers.
  logic [SizeW-1:0] last_q, pend_q, ctrl_q, buf_q;
  logic [SizeW-1:0] limit_q, clamp_q, amp_q, span_q, zb_q, off_q, neps_q, nb_q;
  logic             grow_q, wait_q, wait_d;
  logic             out_valid_q;
  logic [SizeW-1:0] out_ctrl_q, out_buf_q;

  ctl_state_e st_q, st_d;
  md_req_t    md_req;
  md_rsp_t    md_rsp;

  logic             compute, md_start, out_load, in_acc;
  logic [SizeW-1:0] limit_now, to_add, gamma_nz, theta_nz, res_eps;

  asl_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  assign limit_now = sat_add(ctrl_q, buf_q);
  assign to_add    = amp_q - ctrl_q;
  assign gamma_nz  = (gamma_q == '0) ? SizeW'(1) : SizeW'(gamma_q);
  assign theta_nz  = (theta_q == '0) ? SizeW'(1) : SizeW'(theta_q);
  assign res_eps   = grow_q ? sat_add(ctrl_q, md_rsp.result) : ctrl_q - md_rsp.result;

  // Next state: each working state ends when the shared unit reports its result.
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE:  if (in_acc) st_d = S_AMP;
      S_AMP:   if (md_rsp.done) st_d = (md_rsp.result > ctrl_q) ? S_AMPL : S_CSTEP;
      S_AMPL:  if (md_rsp.done) st_d = S_ZB;
      S_ZB:    if (md_rsp.done) st_d = S_OFF;
      S_OFF:   if (md_rsp.done) st_d = S_CSTEP;
      S_CSTEP: if (md_rsp.done) st_d = S_THETA;
      S_THETA: if (md_rsp.done) st_d = grow_q ? S_GAIN : S_FIN;
      S_GAIN:  if (md_rsp.done) st_d = S_FIN;
      S_FIN:   if (out_load) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshakes and operands of the shared unit.
  always_comb begin
    in_ready_o = (st_q == S_IDLE);
    in_acc     = in_valid_i && in_ready_o;
    out_load   = (st_q == S_FIN) && (!out_valid_q || out_ready_i);
    compute    = (st_q != S_IDLE) && (st_q != S_FIN);
    md_start   = compute && !wait_q && !md_rsp.busy;
    wait_d     = md_start ? 1'b1 : (md_rsp.done ? 1'b0 : wait_q);
    md_req.start = md_start;
    md_req.x     = SizeW'(zeta_q);
    md_req.y     = clamp_q;
    md_req.z     = ZETA_UNIT;
    case (st_q)
      S_AMPL: md_req.y = limit_q;
      S_ZB:   md_req.y = buf_q;
      S_OFF: begin
        md_req.x = zb_q;
        md_req.y = to_add;
        md_req.z = span_q;
      end
      S_CSTEP: begin
        md_req.x = grow_q ? sat_sub(to_add, off_q) : ctrl_q - amp_q;
        md_req.y = SizeW'(1);
        md_req.z = gamma_nz;
      end
      S_THETA: begin
        md_req.x = buf_q;
        md_req.y = SizeW'(1);
        md_req.z = theta_nz;
      end
      S_GAIN: begin
        md_req.x = sat_sub(neps_q, ctrl_q);
        md_req.y = SizeW'(gain_q);
        md_req.z = SizeW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
      init_ctrl_q <= SizeW'(1000000);
      init_buf_q  <= SizeW'(1000000);
      gamma_q     <= 32'd37938;
      zeta_q      <= 9'd192;
      theta_q     <= 32'd37938;
      gain_q      <= 8'd10;
      max_ctrl_q  <= ALL_ONES;
      max_buf_q   <= ALL_ONES;
      last_q      <= '0;
      ctrl_q      <= SizeW'(1000000);
      buf_q       <= SizeW'(1000000);
    end else begin
      st_q   <= st_d;
      wait_q <= wait_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (out_load) begin
        // The cap is applied after the floor, so a maximum below the floor wins.
        last_q <= pend_q;
        ctrl_q <= (neps_q < max_ctrl_q) ? neps_q : max_ctrl_q;
        buf_q  <= ((nb_q > init_buf_q) ? nb_q : init_buf_q) < max_buf_q ?
                  ((nb_q > init_buf_q) ? nb_q : init_buf_q) : max_buf_q;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_INIT_CTRL: begin
            init_ctrl_q <= cfg_wdata_i;
            ctrl_q      <= cfg_wdata_i;
          end
          REG_INIT_BUF: begin
            init_buf_q <= cfg_wdata_i;
            buf_q      <= cfg_wdata_i;
          end
          REG_GAMMA_RCP: gamma_q    <= cfg_wdata_i[31:0];
          REG_ZETA:      zeta_q     <= cfg_wdata_i[8:0];
          REG_THETA_RCP: theta_q    <= cfg_wdata_i[31:0];
          REG_BUF_GAIN:  gain_q     <= cfg_wdata_i[7:0];
          REG_MAX_CTRL:  max_ctrl_q <= cfg_wdata_i;
          REG_MAX_BUF:   max_buf_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Working registers load on acceptance and capture each pass of the shared unit as it completes.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_q  <= new_block_size_i;
      limit_q <= limit_now;
      clamp_q <= (last_q < limit_now) ? last_q : limit_now;
    end
    if (out_load) begin
      out_ctrl_q <= (neps_q < max_ctrl_q) ? neps_q : max_ctrl_q;
      out_buf_q  <= ((nb_q > init_buf_q) ? nb_q : init_buf_q) < max_buf_q ?
                    ((nb_q > init_buf_q) ? nb_q : init_buf_q) : max_buf_q;
    end
    if (md_rsp.done) begin
      case (st_q)
        S_AMP: begin
          amp_q  <= md_rsp.result;
          grow_q <= md_rsp.result > ctrl_q;
        end
        S_AMPL:  span_q <= sat_sub(md_rsp.result, ctrl_q);
        S_ZB:    zb_q   <= md_rsp.result;
        S_OFF:   off_q  <= md_rsp.result;
        S_CSTEP: neps_q <= (res_eps > init_ctrl_q) ? res_eps : init_ctrl_q;
        S_THETA: nb_q   <= buf_q - md_rsp.result;
        S_GAIN:  nb_q   <= sat_add(nb_q, md_rsp.result);
        default: ;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign control_size_o = out_ctrl_q;
  assign buffer_size_o  = out_buf_q;

  // The shared unit is only started when it is free.
  a_md_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_req.start |-> !md_rsp.busy)
    else $error("multiply-divide started while busy");

  // A result from the unit only arrives while the sequencer waits for one.
  a_md_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_rsp.done |-> wait_q)
    else $error("unexpected multiply-divide result");

  // An accepted transaction always starts with the amplification pass.
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> st_q == S_AMP)
    else $error("accepted transaction did not start");

  // Loading a result returns the sequencer to idle with the result on show.
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o && st_q == S_IDLE)
    else $error("result not presented");

endmodule
